FILE: sv/sgtr_pkg.sv
// Package for the scaled glyph text renderer: shared types, constants and functions.
// Used by the register block, the draw engine, the top level and the testbench.
// Depends on nothing.
package sgtr_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_SIZE      = 8;
    localparam int SCALE_MAX_DEF   = 8;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [6:0]  LINE_GAP     = 7'd4;

    localparam int APB_AW = 4;

    localparam logic [1:0] REG_PITCH = 2'd0;
    localparam logic [1:0] REG_COLOR = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam logic [14:0] PITCH_RST = 15'd4096;
    localparam logic [31:0] COLOR_RST = 32'hFFFF_FFFF;
    localparam logic [3:0]  SCALE_RST = 4'd1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CHAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOP,
        ST_ADDR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [14:0] line_pitch_bytes;
        logic [31:0] text_color;
        logic [3:0]  scale_factor;
    } cfg_t;

    // Each glyph pixel becomes a run of s mask bits; bit 7 of the row is leftmost.
    function automatic logic [63:0] widen_row(input logic [7:0] bits, input logic [3:0] s);
        logic [63:0] mask;
        logic [5:0]  idx;
        mask = '0;
        for (int j = 0; j < 8; j++)
        begin
            for (int dx = 0; dx < 8; dx++)
            begin
                idx = 6'(j * int'(s) + dx);
                if (bits[7 - j] && (dx < int'(s)))
                begin
                    mask[idx] = 1'b1;
                end
            end
        end
        return mask;
    endfunction

endpackage

FILE: sv/sgtr_if.sv
// Channel interfaces of the scaled glyph text renderer: command input and row output.
// Each carries valid, ready and the payload; a transaction completes when both are high.
// Depends on nothing.
interface sgtr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  code;
    logic [2:0]  glyph_row;
    logic [7:0]  row_bits;
    logic [11:0] start_x;
    logic [11:0] start_y;

    modport source (output valid, cmd, code, glyph_row, row_bits, start_x, start_y,
                    input ready);
    modport sink   (input valid, cmd, code, glyph_row, row_bits, start_x, start_y,
                    output ready);
endinterface

interface sgtr_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_address;
    logic [63:0] pixel_mask;
    logic [6:0]  pixel_count;
    logic [31:0] pixel_value;
    logic        last_row;

    modport source (output valid, pixel_address, pixel_mask, pixel_count, pixel_value,
                    last_row, input ready);
    modport sink   (input valid, pixel_address, pixel_mask, pixel_count, pixel_value,
                    last_row, output ready);
endinterface

FILE: sv/sgtr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module sgtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/sgtr_regs.sv
// APB configuration registers of the scaled glyph text renderer.
// Depends on sgtr_pkg.
module sgtr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sgtr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output sgtr_pkg::cfg_t              cfg
);
    import sgtr_pkg::*;

    logic [14:0] pitch_reg, pitch_next;
    logic [31:0] color_reg, color_next;
    logic [3:0]  scale_reg, scale_next;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        pitch_next = pitch_reg;
        color_next = color_reg;
        scale_next = scale_reg;
        prdata     = '0;
        unique case (paddr[3:2])
            REG_PITCH:
            begin
                prdata = 32'(pitch_reg);
                if (wr)
                begin
                    pitch_next = pwdata[14:0];
                end
            end
            REG_COLOR:
            begin
                prdata = color_reg;
                if (wr)
                begin
                    color_next = pwdata;
                end
            end
            REG_SCALE:
            begin
                prdata = 32'(scale_reg);
                if (wr)
                begin
                    scale_next = pwdata[3:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= PITCH_RST;
            color_reg <= COLOR_RST;
            scale_reg <= SCALE_RST;
        end
        else
        begin
            pitch_reg <= pitch_next;
            color_reg <= color_next;
            scale_reg <= scale_next;
        end
    end

    assign cfg = '{line_pitch_bytes: pitch_reg, text_color: color_reg, scale_factor: scale_reg};

endmodule

FILE: sv/sgtr_draw.sv
// Draw engine of the scaled glyph text renderer: command decode, cursor state,
// address arithmetic, font store access and the registered output stage.
// Depends on sgtr_pkg and the channel interfaces.
module sgtr_draw #(
    parameter int GLYPH_COUNT = sgtr_pkg::GLYPH_COUNT_DEF,
    parameter int SCALE_MAX   = sgtr_pkg::SCALE_MAX_DEF,
    parameter int FAW         = $clog2(GLYPH_COUNT) + 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sgtr_pkg::cfg_t  cfg,
    sgtr_in_if.sink         in_ch,
    sgtr_out_if.source      out_ch,
    output logic            font_wr_en,
    output logic [FAW-1:0]  font_wr_addr,
    output logic [7:0]      font_wr_data,
    output logic [FAW-1:0]  font_rd_addr,
    input  logic [7:0]      font_rd_data
);
    import sgtr_pkg::*;

    localparam int GW = FAW - 3;

    state_t      state_reg, state_next;
    logic [12:0] cursor_reg, cursor_next;
    logic [11:0] line_start_reg, line_start_next;
    logic [11:0] base_y_reg, base_y_next;
    logic [15:0] line_cnt_reg, line_cnt_next;
    logic [GW-1:0] glyph_reg, glyph_next;
    logic [23:0] top_reg, top_next;
    logic [23:0] addr_reg, addr_next;
    logic [5:0]  row_reg, row_next;
    logic [2:0]  dx_reg, dx_next;
    logic [2:0]  i_reg, i_next;
    logic        out_valid_reg, out_valid_next;

    logic [23:0] out_addr_reg;
    logic [63:0] out_mask_reg;
    logic [6:0]  out_count_reg;
    logic [31:0] out_color_reg;
    logic        out_last_reg;

    logic [3:0]  s;
    logic [6:0]  rows;
    logic [6:0]  gap;
    logic [22:0] line_off;
    logic [12:0] words;
    logic [6:0]  s_sq;
    logic [7:0]  adv;
    logic [GW-1:0] glyph_idx;
    logic        accept;
    logic        out_load;
    logic        last;

    always_comb
    begin
        if (cfg.scale_factor == 4'd0)
        begin
            s = 4'd1;
        end
        else if (cfg.scale_factor > 4'(SCALE_MAX))
        begin
            s = 4'(SCALE_MAX);
        end
        else
        begin
            s = cfg.scale_factor;
        end
    end

    assign rows     = {s, 3'b000};
    assign gap      = rows + LINE_GAP;
    assign line_off = 23'(line_cnt_reg) * 23'(gap);
    assign words    = cfg.line_pitch_bytes[14:2];
    assign s_sq     = 7'(s) * 7'(s);
    assign adv      = 8'(s_sq) + {s_sq, 1'b0};
    assign last     = (row_reg == 6'(rows - 7'd1));

    // Codes are 8 bits wide, so one conditional subtract folds them only when the glyph count is at least 128.
    assign glyph_idx = ({1'b0, in_ch.code} >= 9'(GLYPH_COUNT))
                     ? GW'({1'b0, in_ch.code} - 9'(GLYPH_COUNT))
                     : GW'(in_ch.code);

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign font_wr_en   = accept && (cmd_t'(in_ch.cmd) == CMD_LOAD);
    assign font_wr_addr = {glyph_idx, in_ch.glyph_row};
    assign font_wr_data = in_ch.row_bits;
    // The read address follows the next glyph row, so in the emit state the read data always
    // belongs to the row counter's current value.
    assign font_rd_addr = {glyph_reg, i_next};

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        line_start_next = line_start_reg;
        base_y_next     = base_y_reg;
        line_cnt_next   = line_cnt_reg;
        glyph_next      = glyph_reg;
        top_next        = top_reg;
        addr_next       = addr_reg;
        row_next        = row_reg;
        dx_next         = dx_reg;
        i_next          = i_reg;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(in_ch.cmd))
                        CMD_LOAD:
                        begin
                        end
                        CMD_START:
                        begin
                            line_start_next = in_ch.start_x;
                            cursor_next     = 13'(in_ch.start_x);
                            base_y_next     = in_ch.start_y;
                        end
                        CMD_CHAR:
                        begin
                            if (in_ch.code == NEWLINE_CODE)
                            begin
                                cursor_next   = 13'(line_start_reg);
                                line_cnt_next = line_cnt_reg + 16'd1;
                            end
                            else
                            begin
                                glyph_next = glyph_idx;
                                row_next   = '0;
                                dx_next    = '0;
                                i_next     = '0;
                                state_next = ST_TOP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TOP:
            begin
                top_next   = 24'(base_y_reg) + 24'(line_off);
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                addr_next  = 24'(top_reg) * 24'(words) + 24'(cursor_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load  = 1'b1;
                    addr_next = addr_reg + 24'(words);
                    row_next  = row_reg + 6'd1;
                    if ({1'b0, dx_reg} == s - 4'd1)
                    begin
                        dx_next = '0;
                        i_next  = i_reg + 3'd1;
                    end
                    else
                    begin
                        dx_next = dx_reg + 3'd1;
                    end
                    if (last)
                    begin
                        cursor_next = cursor_reg + 13'(adv);
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            line_start_reg <= '0;
            base_y_reg     <= '0;
            line_cnt_reg   <= '0;
            glyph_reg      <= '0;
            row_reg        <= '0;
            dx_reg         <= '0;
            i_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            line_start_reg <= line_start_next;
            base_y_reg     <= base_y_next;
            line_cnt_reg   <= line_cnt_next;
            glyph_reg      <= glyph_next;
            row_reg        <= row_next;
            dx_reg         <= dx_next;
            i_reg          <= i_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        addr_reg <= addr_next;
        if (out_load)
        begin
            out_addr_reg  <= addr_reg;
            out_mask_reg  <= widen_row(font_rd_data, s);
            out_count_reg <= rows;
            out_color_reg <= cfg.text_color;
            out_last_reg  <= last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_address = out_addr_reg;
    assign out_ch.pixel_mask    = out_mask_reg;
    assign out_ch.pixel_count   = out_count_reg;
    assign out_ch.pixel_value   = out_color_reg;
    assign out_ch.last_row      = out_last_reg;

endmodule

FILE: sv/scaled_glyph_text_renderer.sv
// Font loads, start commands and newlines leave the engine idle, so the next transaction is
// accepted in the following cycle. A drawn character first passes the address set-up states
// (line offset multiply, then base address multiply) and then emits one row per cycle out of
// the font store while the output is not stalled, 8*scale rows in all. The first row is
// registered at the output from the emit state. Reset clears the state, cursor, line counter,
// output valid and configuration registers; the font store is not cleared.
module scaled_glyph_text_renderer #(
    parameter int GLYPH_COUNT = sgtr_pkg::GLYPH_COUNT_DEF,
    parameter int SCALE_MAX   = sgtr_pkg::SCALE_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sgtr_in_if.sink                     in_ch,
    sgtr_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sgtr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sgtr_pkg::*;

    localparam int FAW = $clog2(GLYPH_COUNT) + 3;

    cfg_t           cfg;
    logic           font_wr_en;
    logic [FAW-1:0] font_wr_addr;
    logic [7:0]     font_wr_data;
    logic [FAW-1:0] font_rd_addr;
    logic [7:0]     font_rd_data;

    sgtr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sgtr_ram #(
        .WIDTH (GLYPH_SIZE),
        .DEPTH (GLYPH_COUNT * GLYPH_SIZE),
        .AW    (FAW)
    ) u_font (
        .clk     (clk),
        .wr_en   (font_wr_en),
        .wr_addr (font_wr_addr),
        .wr_data (font_wr_data),
        .rd_addr (font_rd_addr),
        .rd_data (font_rd_data)
    );

    sgtr_draw #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .SCALE_MAX   (SCALE_MAX),
        .FAW         (FAW)
    ) u_draw (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .font_wr_en   (font_wr_en),
        .font_wr_addr (font_wr_addr),
        .font_wr_data (font_wr_data),
        .font_rd_addr (font_rd_addr),
        .font_rd_data (font_rd_data)
    );

endmodule

FILE: verif/scaled_glyph_text_renderer_tb.sv
// Self-checking testbench for the scaled glyph text renderer: font loads, start commands,
// characters and newlines are driven under random idling, and every emitted row is compared
// with a row predictor. Depends on sgtr_pkg, the channel interfaces and the renderer itself.
module scaled_glyph_text_renderer_tb;
    import sgtr_pkg::*;

    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         WATCHDOG_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         DRAIN_CYCLES     = 100;
    localparam int         PHASE_ITEMS      = 48;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  code;
        logic [2:0]  glyph_row;
        logic [7:0]  row_bits;
        logic [11:0] start_x;
        logic [11:0] start_y;
    } command_t;

    typedef struct packed {
        logic [23:0] pixel_address;
        logic [63:0] pixel_mask;
        logic [6:0]  pixel_count;
        logic [31:0] pixel_value;
        logic        last_row;
    } glyph_row_t;

    class glyph_row_scoreboard;
        logic [7:0]  font_rows [0:2047];
        logic [12:0] cursor_x;
        logic [11:0] line_start_x;
        logic [11:0] base_y;
        logic [15:0] line_count;
        logic [14:0] pitch;
        logic [31:0] color;
        logic [3:0]  scale;
        glyph_row_t  pending_rows [$];
        int unsigned errors;

        function new();
            cursor_x     = '0;
            line_start_x = '0;
            base_y       = '0;
            line_count   = '0;
            pitch        = PITCH_RST;
            color        = COLOR_RST;
            scale        = SCALE_RST;
            errors       = 0;
        endfunction

        function void set_register(input logic [1:0] index, input logic [31:0] value);
            case (index)
                REG_PITCH: pitch = value[14:0];
                REG_COLOR: color = value;
                REG_SCALE: scale = value[3:0];
                default: ;
            endcase
        endfunction

        function void note_command(input command_t c);
            int unsigned       s;
            int unsigned       rows;
            longint unsigned   words;
            longint unsigned   top;
            longint unsigned   y;
            logic [7:0]        bits;
            glyph_row_t        row;
            case (c.cmd)
                CMD_LOAD:
                begin
                    font_rows[{c.code, c.glyph_row}] = c.row_bits;
                end
                CMD_START:
                begin
                    line_start_x = c.start_x;
                    cursor_x     = {1'b0, c.start_x};
                    base_y       = c.start_y;
                end
                CMD_CHAR:
                begin
                    if (c.code == NEWLINE_CODE)
                    begin
                        cursor_x   = {1'b0, line_start_x};
                        line_count = line_count + 16'd1;
                    end
                    else
                    begin
                        s = scale;
                        if (s < 1)
                            s = 1;
                        if (s > SCALE_MAX_DEF)
                            s = SCALE_MAX_DEF;
                        rows  = 8 * s;
                        words = pitch >> 2;
                        top   = base_y;
                        top   = top + line_count * (8 * s + LINE_GAP);
                        for (int r = 0; r < rows; r++)
                        begin
                            bits = font_rows[{c.code, 3'(r / s)}];
                            y    = top + r;
                            row.pixel_address = 24'(y * words + cursor_x);
                            row.pixel_mask    = '0;
                            for (int j = 0; j < 8; j++)
                            begin
                                if (bits[7 - j])
                                begin
                                    for (int dx = 0; dx < s; dx++)
                                        row.pixel_mask[j * s + dx] = 1'b1;
                                end
                            end
                            row.pixel_count = 7'(rows);
                            row.pixel_value = color;
                            row.last_row    = (r == rows - 1);
                            pending_rows.push_back(row);
                        end
                        cursor_x = cursor_x + 13'(3 * s * s);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_row(input glyph_row_t got);
            glyph_row_t want;
            if (pending_rows.size() == 0)
            begin
                $error("unexpected row transaction at pixel_address %h", got.pixel_address);
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            if (got.pixel_address !== want.pixel_address)
            begin
                $error("pixel_address expected %h got %h", want.pixel_address, got.pixel_address);
                errors++;
            end
            if (got.pixel_mask !== want.pixel_mask)
            begin
                $error("pixel_mask expected %h got %h", want.pixel_mask, got.pixel_mask);
                errors++;
            end
            if (got.pixel_count !== want.pixel_count)
            begin
                $error("pixel_count expected %0d got %0d", want.pixel_count, got.pixel_count);
                errors++;
            end
            if (got.pixel_value !== want.pixel_value)
            begin
                $error("pixel_value expected %h got %h", want.pixel_value, got.pixel_value);
                errors++;
            end
            if (got.last_row !== want.last_row)
            begin
                $error("last_row expected %b got %b", want.last_row, got.last_row);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    sgtr_in_if  in_ch ();
    sgtr_out_if out_ch ();

    scaled_glyph_text_renderer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    glyph_row_scoreboard sb = new();

    bit         idle_on;
    bit         hold_request;
    int         quiet_cycles;
    logic [7:0] loaded_rows [0:255];
    bit         glyph_ready [0:255];
    logic [7:0] ready_glyphs [$];

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int p;
        if (!idle_on)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 70)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic command_t random_command(input logic [1:0] cmd);
        command_t c;
        c.cmd       = cmd;
        c.code      = 8'($urandom);
        c.glyph_row = 3'($urandom);
        c.row_bits  = 8'($urandom);
        c.start_x   = 12'($urandom);
        c.start_y   = 12'($urandom);
        return c;
    endfunction

    task automatic send_command(input command_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= c.cmd;
        in_ch.code      <= c.code;
        in_ch.glyph_row <= c.glyph_row;
        in_ch.row_bits  <= c.row_bits;
        in_ch.start_x   <= c.start_x;
        in_ch.start_y   <= c.start_y;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic load_row(input logic [7:0] code, input logic [2:0] row,
                            input logic [7:0] bits);
        command_t c;
        c           = random_command(CMD_LOAD);
        c.code      = code;
        c.glyph_row = row;
        c.row_bits  = bits;
        loaded_rows[code][row] = 1'b1;
        if (loaded_rows[code] == 8'hFF && !glyph_ready[code])
        begin
            glyph_ready[code] = 1'b1;
            ready_glyphs.push_back(code);
        end
        send_command(c);
    endtask

    task automatic put_glyph(input logic [7:0] code);
        command_t c;
        c      = random_command(CMD_CHAR);
        c.code = code;
        send_command(c);
    endtask

    task automatic start_line(input logic [11:0] x, input logic [11:0] y);
        command_t c;
        c         = random_command(CMD_START);
        c.start_x = x;
        c.start_y = y;
        send_command(c);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending_rows.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(index, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random(input int target);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                n = $urandom_range(0, 255);
                for (int row = 0; row < 8; row++)
                    load_row(8'(n), 3'(row), 8'($urandom));
                sent += 8;
            end
            else if (pick < 60)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 6) == 0)
                        put_glyph(NEWLINE_CODE);
                    else
                        put_glyph(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]);
                end
                sent += n;
            end
            else if (pick < 70)
            begin
                start_line(12'($urandom), 12'($urandom));
                sent++;
            end
            else if (pick < 82)
            begin
                load_row(8'($urandom), 3'($urandom), 8'($urandom));
                sent++;
            end
            else if (pick < 90)
            begin
                put_glyph(NEWLINE_CODE);
                sent++;
            end
            else
            begin
                send_command(random_command(CMD_UNUSED));
            end
        end
    endtask

    initial
    begin : output_sink
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_command('{in_ch.cmd, in_ch.code, in_ch.glyph_row, in_ch.row_bits,
                                  in_ch.start_x, in_ch.start_y});
            if (out_ch.valid && out_ch.ready)
                sb.check_row('{out_ch.pixel_address, out_ch.pixel_mask, out_ch.pixel_count,
                               out_ch.pixel_value, out_ch.last_row});
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] pitch_value;
        logic [31:0] color_value;
        logic [31:0] scale_value;
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = '0;
        in_ch.code      = '0;
        in_ch.glyph_row = '0;
        in_ch.row_bits  = '0;
        in_ch.start_x   = '0;
        in_ch.start_y   = '0;
        idle_on         = 1'b1;
        hold_request    = 1'b0;
        quiet_cycles    = 0;
        for (int g = 0; g < 256; g++)
        begin
            loaded_rows[g] = '0;
            glyph_ready[g] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_row(8'hFF, 3'd0, 8'hFF);
        load_row(8'hFF, 3'd1, 8'h00);
        load_row(8'hFF, 3'd2, 8'h80);
        load_row(8'hFF, 3'd3, 8'h01);
        load_row(8'hFF, 3'd4, 8'hAA);
        load_row(8'hFF, 3'd5, 8'h55);
        load_row(8'hFF, 3'd6, 8'hFF);
        load_row(8'hFF, 3'd7, 8'h3C);
        put_glyph(8'hFF);
        send_command('{CMD_UNUSED, 8'hFF, 3'h7, 8'hFF, 12'hFFF, 12'hFFF});
        start_line(12'hFFF, 12'hFFF);
        put_glyph(8'hFF);
        put_glyph(NEWLINE_CODE);
        put_glyph(8'hFF);
        put_glyph(8'hFF);
        start_line(12'h000, 12'h000);
        put_glyph(8'hFF);
        load_row(8'h00, 3'd0, 8'h00);

        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            color_value = $urandom;
            case (ph)
                0:
                begin
                    pitch_value = 0;
                    color_value = 32'h0000_0000;
                    scale_value = 0;
                end
                1:
                begin
                    pitch_value = 32767;
                    color_value = 32'hFFFF_FFFF;
                    scale_value = 8;
                end
                2:
                begin
                    pitch_value = 3;
                    scale_value = 15;
                end
                3:
                begin
                    pitch_value = 4;
                    scale_value = 2;
                end
                4:
                begin
                    pitch_value = 16384;
                    scale_value = $urandom_range(1, 8);
                end
                5:
                begin
                    pitch_value = $urandom_range(4, 16384);
                    scale_value = $urandom_range(0, 15);
                end
                default:
                begin
                    pitch_value = $urandom_range(0, 32767);
                    scale_value = 1;
                end
            endcase
            write_register(REG_PITCH, pitch_value);
            write_register(REG_COLOR, color_value);
            write_register(REG_SCALE, scale_value);
            idle_on = (ph != 4);
            if (ph == 1)
            begin
                start_line(12'hFFF, 12'hFFF);
                repeat (24) put_glyph(8'hFF);
            end
            if (ph == 2)
            begin
                hold_request = 1'b1;
                repeat (10) put_glyph(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]);
            end
            run_random(PHASE_ITEMS);
        end

        in_ch.valid <= 1'b0;
        while (sb.pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_rows.size() != 0)
        begin
            $error("%0d expected rows never arrived", sb.pending_rows.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: sim.f
sv/sgtr_pkg.sv
sv/sgtr_if.sv
sv/sgtr_ram.sv
sv/sgtr_regs.sv
sv/sgtr_draw.sv
sv/scaled_glyph_text_renderer.sv
verif/scaled_glyph_text_renderer_tb.sv
